/* design/pcpd_pkg.sv */
// Package for the patch column post decoder: widths, op codes, parse phases
// and the result word handed from the parser to the output pipeline.
// No dependencies.
`default_nettype none

package pcpd_pkg;

	localparam int MAX_COLUMNS   = 1024; // power of two, 64..4096
	localparam int PALETTE_DEPTH = 256;
	localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

	localparam int COL_W    = 10;
	localparam int ROW_W    = 9;
	localparam int HEIGHT_W = 10;
	localparam int RGB_W    = 24;

	// columns wrap modulo MAX_COLUMNS; a 10-bit field never reaches 1024 and up
	localparam logic [COL_W-1:0] COL_MASK =
		(MAX_COLUMNS >= (1 << COL_W)) ? {COL_W{1'b1}} : COL_W'(MAX_COLUMNS - 1);

	localparam logic [7:0] END_MARK = 8'd255;

	typedef enum logic [1:0] {
		OP_PAL_WRITE = 2'd0,
		OP_COL_START = 2'd1,
		OP_COL_DATA  = 2'd2,
		OP_UNUSED    = 2'd3
	} pcpd_op_t;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_END   = 1'b1;

	typedef enum logic [5:0] {
		PH_ROW    = 6'b000001,
		PH_COUNT  = 6'b000010,
		PH_PAD    = 6'b000100,
		PH_PIXELS = 6'b001000,
		PH_TAIL   = 6'b010000,
		PH_DONE   = 6'b100000
	} pcpd_phase_t;

	// what the parser decides for one accepted word
	typedef struct packed {
		logic              valid;   // a result word follows
		logic              kind;
		logic [COL_W-1:0]  column;
		logic [ROW_W-1:0]  row;
		logic              rd_en;   // palette read issued this cycle
		logic [PAL_AW-1:0] rd_addr;
	} pcpd_res_t;

endpackage

`default_nettype wire

/* design/pcpd_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued. No dependencies.
`default_nettype none

module pcpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* design/pcpd_parser.sv */
// Post stream parser: phase register and post counters, one step per
// accepted word. Depends on pcpd_pkg.
`default_nettype none

module pcpd_parser import pcpd_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire logic [1:0]          op,
	input  wire logic [COL_W-1:0]    index,
	input  wire logic [7:0]          data_byte,
	input  wire logic [HEIGHT_W-1:0] image_height,
	output pcpd_res_t                res
);

	pcpd_phase_t      phase_q;
	logic [COL_W-1:0] column_q;
	logic [7:0]       start_row_q;
	logic [7:0]       left_q;
	logic [7:0]       offset_q;

	logic [ROW_W-1:0] row;
	logic             is_data;

	assign row     = ROW_W'({1'b0, start_row_q} + {1'b0, offset_q});
	assign is_data = accept && (pcpd_op_t'(op) == OP_COL_DATA);

	always_comb begin
		res         = '0;
		res.column  = column_q;
		res.row     = row;
		res.kind    = KIND_PIXEL;
		res.rd_addr = data_byte[PAL_AW-1:0];
		if (is_data) begin
			unique case (phase_q)
				PH_ROW: begin
					if (data_byte == END_MARK) begin
						res.valid = 1'b1;
						res.kind  = KIND_END;
						res.row   = '0;
					end
				end
				PH_PIXELS: begin
					// rows at or past the picture height are dropped, no read
					if ({1'b0, row} < image_height) begin
						res.valid = 1'b1;
						res.rd_en = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_ROW;
			column_q    <= '0;
			start_row_q <= '0;
			left_q      <= '0;
			offset_q    <= '0;
		end else if (accept && pcpd_op_t'(op) == OP_COL_START) begin
			phase_q     <= PH_ROW;
			column_q    <= index & COL_MASK;
			start_row_q <= '0;
			left_q      <= '0;
			offset_q    <= '0;
		end else if (is_data) begin
			unique case (phase_q)
				PH_ROW: begin
					if (data_byte == END_MARK) begin
						phase_q <= PH_DONE;
					end else begin
						start_row_q <= data_byte;
						phase_q     <= PH_COUNT;
					end
				end
				PH_COUNT: begin
					left_q   <= data_byte;
					offset_q <= '0;
					phase_q  <= PH_PAD;
				end
				PH_PAD: begin
					phase_q <= (left_q == '0) ? PH_TAIL : PH_PIXELS;
				end
				PH_PIXELS: begin
					offset_q <= offset_q + 8'd1;
					left_q   <= left_q - 8'd1;
					if (left_q == 8'd1) begin
						phase_q <= PH_TAIL;
					end
				end
				PH_TAIL: begin
					phase_q <= PH_ROW;
				end
				PH_DONE: ;
				default: phase_q <= PH_ROW;
			endcase
		end
	end

endmodule

`default_nettype wire

/* design/patch_column_post_decoder_core.sv */
// Top level of the patch column post decoder: parser, palette RAM, one
// pipeline stage and the output register. Depends on pcpd_pkg, pcpd_ram, pcpd_parser.
`default_nettype none

// One input word is taken every cycle unless the input stalls, for any mix of
// palette writes, column starts and data bytes; a byte's result word goes
// through stage 1 and the output register. The rate is set by the palette RAM:
// each data byte needs one read of its single read port, and that read is
// issued in the cycle the byte is accepted. Palette writes go through the
// separate write port, and a read in the cycle after a write already sees
// the new colour, so no forwarding is needed. The palette comes up
// undefined and has no clearing pass: load every entry a picture uses
// before sending its columns. image_height may only be changed while the
// block is idle. Input stalls only when both the pipeline stage and the
// output register hold words and the output is not being taken.
module patch_column_post_decoder_core import pcpd_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,

	input  wire logic                cfg_we,
	input  wire logic [HEIGHT_W-1:0] cfg_wdata,

	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [1:0]          op,
	input  wire logic [COL_W-1:0]    index,
	input  wire logic [RGB_W-1:0]    colour,
	input  wire logic [7:0]          data_byte,

	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     kind,
	output logic [COL_W-1:0]         column,
	output logic [ROW_W-1:0]         row,
	output logic [7:0]               red,
	output logic [7:0]               green,
	output logic [7:0]               blue
);

	logic [HEIGHT_W-1:0] image_height_q;

	logic             accept;
	pcpd_res_t        res;
	logic [RGB_W-1:0] pal_rdata;

	// stage 1: result metadata while the palette read is in flight
	logic             valid_s1;
	logic             kind_s1;
	logic [COL_W-1:0] column_s1;
	logic [ROW_W-1:0] row_s1;
	logic             adv_s1;

	assign adv_s1   = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || !out_valid || out_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_height_q <= HEIGHT_W'(128);
		end else if (cfg_we) begin
			image_height_q <= cfg_wdata;
		end
	end

	pcpd_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.op           (op),
		.index        (index),
		.data_byte    (data_byte),
		.image_height (image_height_q),
		.res          (res)
	);

	// read data holds while stage 1 is stalled, since no new byte is taken then
	pcpd_ram #(
		.WIDTH (RGB_W),
		.DEPTH (PALETTE_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (accept && pcpd_op_t'(op) == OP_PAL_WRITE),
		.waddr (index[PAL_AW-1:0]),
		.wdata (colour),
		.re    (res.rd_en),
		.raddr (res.rd_addr),
		.rdata (pal_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= res.valid;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= res.kind;
			column_s1 <= res.column;
			row_s1    <= res.row;
		end
	end

	// output register; end-of-column words carry a zero colour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			kind   <= kind_s1;
			column <= column_s1;
			row    <= row_s1;
			if (kind_s1 == KIND_END) begin
				red   <= '0;
				green <= '0;
				blue  <= '0;
			end else begin
				red   <= pal_rdata[23:16];
				green <= pal_rdata[15:8];
				blue  <= pal_rdata[7:0];
			end
		end
	end

endmodule

`default_nettype wire

/* design/pcpd_checker.sv */
// Port-level checks for patch_column_post_decoder_core and the bind that
// attaches them. Depends on pcpd_pkg and the top level.
`default_nettype none

module pcpd_checker import pcpd_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic             kind,
	input wire logic [COL_W-1:0] column,
	input wire logic [ROW_W-1:0] row,
	input wire logic [7:0]       red,
	input wire logic [7:0]       green,
	input wire logic [7:0]       blue
);

	// a stalled result word stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// an end-of-column word carries row and colour zero
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_END |->
			row == '0 && red == '0 && green == '0 && blue == '0)
		else $error("end word with nonzero row or colour");

	// input only backs up behind a waiting result word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// a word that waits keeps its column across the stall
	a_column_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(column) && $stable(kind))
		else $error("result word changed while stalled");

endmodule

bind patch_column_post_decoder_core pcpd_checker u_pcpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.kind      (kind),
	.column    (column),
	.row       (row),
	.red       (red),
	.green     (green),
	.blue      (blue)
);

`default_nettype wire

/* tb/sv/tb_patch_column_post_decoder_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for patch_column_post_decoder_core: random and directed post
// streams, an in-bench predictor of the parse and palette, random stalls on both sides.
// Depends on pcpd_pkg and the design top level.

module tb_patch_column_post_decoder_core;
	import pcpd_pkg::*;

	// One output word as it appears on the result port.
	// The packed field order is the same as the port order.
	typedef struct packed {
		logic             kind;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
	} pixel_word_t;

	// Column post parser and palette, kept in step with the accepted input words.
	// It also holds the pixel and column-end words that are still expected.
	class column_pixel_scoreboard;
		logic [RGB_W-1:0]    palette [PALETTE_DEPTH];
		bit                  written [PALETTE_DEPTH];
		logic [7:0]          written_list[$];
		pcpd_phase_t         phase;
		logic [COL_W-1:0]    cur_col;
		logic [7:0]          start_row;
		logic [7:0]          left;
		logic [7:0]          offset;
		logic [HEIGHT_W-1:0] height;
		pixel_word_t         expected_pixels[$];
		int                  mismatches;
		int                  pixels_seen;
		int                  ends_seen;

		function new();
			phase = PH_ROW;
			cur_col = '0;
			start_row = '0;
			left = '0;
			offset = '0;
			height = HEIGHT_W'(128);
			mismatches = 0;
			pixels_seen = 0;
			ends_seen = 0;
		endfunction

		function logic [7:0] pick_written();
			return written_list[$urandom_range(0, written_list.size() - 1)];
		endfunction

		function void note_word(pcpd_op_t opc, logic [COL_W-1:0] idx, logic [RGB_W-1:0] rgb,
				logic [7:0] b);
			logic [ROW_W-1:0] r;
			pixel_word_t      w;
			case (opc)
				OP_PAL_WRITE: begin
					// only the low address bits select the entry
					palette[idx[PAL_AW-1:0]] = rgb;
					if (!written[idx[PAL_AW-1:0]]) begin
						written[idx[PAL_AW-1:0]] = 1'b1;
						written_list.insert(written_list.size(), idx[PAL_AW-1:0]);
					end
				end
				OP_COL_START: begin
					cur_col = idx & COL_MASK;
					phase = PH_ROW;
					start_row = '0;
					left = '0;
					offset = '0;
				end
				OP_COL_DATA: begin
					case (phase)
						PH_ROW: begin
							if (b == END_MARK) begin
								phase = PH_DONE;
								w = {KIND_END, cur_col, {ROW_W{1'b0}}, 24'h0};
								expected_pixels.insert(expected_pixels.size(), w);
							end else begin
								start_row = b;
								phase = PH_COUNT;
							end
						end
						PH_COUNT: begin
							left = b;
							offset = '0;
							phase = PH_PAD;
						end
						PH_PAD: phase = (left == 0) ? PH_TAIL : PH_PIXELS;
						PH_PIXELS: begin
							r = {1'b0, start_row} + {1'b0, offset};
							offset = offset + 8'd1;
							left = left - 8'd1;
							if (left == 0)
								phase = PH_TAIL;
							if ({1'b0, r} < height) begin
								w = {KIND_PIXEL, cur_col, r, palette[b]};
								expected_pixels.insert(expected_pixels.size(), w);
							end
						end
						PH_TAIL: phase = PH_ROW;
						default: ;
					endcase
				end
				default: ;
			endcase
		endfunction

		function void check_word(pixel_word_t got);
			pixel_word_t exp_w;
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: word with nothing expected: kind %0d col %0d row %0d rgb %06h",
						$realtime, got.kind, got.column, got.row, {got.red, got.green, got.blue});
				return;
			end
			exp_w = expected_pixels.pop_front();
			if (got.kind !== exp_w.kind || got.column !== exp_w.column || got.row !== exp_w.row
					|| got.red !== exp_w.red || got.green !== exp_w.green
					|| got.blue !== exp_w.blue) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch: expected kind %0d col %0d row %0d rgb %06h,",
						$realtime, exp_w.kind, exp_w.column, exp_w.row,
						{exp_w.red, exp_w.green, exp_w.blue},
						" got kind %0d col %0d row %0d rgb %06h",
						got.kind, got.column, got.row, {got.red, got.green, got.blue});
			end
			if (exp_w.kind == KIND_END)
				ends_seen++;
			else
				pixels_seen++;
		endfunction
	endclass

	// clock, reset and block ports; every input starts at a known value
	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [HEIGHT_W-1:0] cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [1:0]          op = '0;
	logic [COL_W-1:0]    index = '0;
	logic [RGB_W-1:0]    colour = '0;
	logic [7:0]          data_byte = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                kind;
	logic [COL_W-1:0]    column;
	logic [ROW_W-1:0]    row;
	logic [7:0]          red;
	logic [7:0]          green;
	logic [7:0]          blue;

	column_pixel_scoreboard sb = new();

	bit no_idle = 1'b0;     // a phase with back-to-back traffic on both sides
	int work_words = 0;     // words the block acts on
	int ignored_words = 0;  // unused op, or data after the end marker
	int heights_run = 1;    // reset height counts as the first

	patch_column_post_decoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.index     (index),
		.colour    (colour),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.column    (column),
		.row       (row),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Gap length for either side: mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// Output side: ready drops for random stretches, independent of the data.
	// A word is taken at a rising edge with valid and ready high.
	initial begin
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_word({kind, column, row, red, green, blue});
	end

	// Drive one input word and hold it until the block takes it. Inputs change on
	// the falling edge; acceptance is seen at the rising edge. A pixel index
	// byte is steered to a palette entry that has already been loaded, since
	// the palette RAM comes up undefined.
	task automatic send_word(input pcpd_op_t opc, input logic [COL_W-1:0] idx,
			input logic [RGB_W-1:0] rgb, input logic [7:0] b);
		int gap;
		bit ignored;
		gap = pick_gap();
		if (opc == OP_COL_DATA && sb.phase == PH_PIXELS && !sb.written[b])
			b = sb.pick_written();
		ignored = (opc == OP_UNUSED) || (opc == OP_COL_DATA && sb.phase == PH_DONE);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= opc;
		index <= idx;
		colour <= rgb;
		data_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_word(opc, idx, rgb, b);
		if (ignored)
			ignored_words++;
		else
			work_words++;
	endtask

	task automatic data_word(input logic [7:0] b);
		send_word(OP_COL_DATA, COL_W'($urandom), RGB_W'($urandom), b);
	endtask

	// Wait until every expected word is out, plus a margin for words still in the
	// two-stage pipe that produce nothing.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Height may only change while the block is idle.
	task automatic set_height(input int h);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= HEIGHT_W'(h);
		@(posedge clk);
		sb.height = HEIGHT_W'(h);
		@(negedge clk);
		cfg_we <= 1'b0;
		heights_run++;
	endtask

	// Occasional palette write or unused op dropped in between stream bytes.
	task automatic maybe_noise();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			send_word(OP_PAL_WRITE, COL_W'($urandom), RGB_W'($urandom), 8'($urandom));
		else if (r < 8)
			send_word(OP_UNUSED, COL_W'($urandom), RGB_W'($urandom), 8'($urandom));
	endtask

	// One post: start row, count, pad, indices, tail. Now and then it is cut
	// short, which leaves the parser out of step until the next column start.
	task automatic gen_post();
		int base;
		int cnt;
		int cut;
		int r;
		logic [7:0] start;
		base = (sb.height > 254) ? 254 : int'(sb.height);
		if ($urandom_range(0, 1))
			start = 8'($urandom_range(0, 254));
		else
			start = 8'(base - int'($urandom_range(0, (base < 8) ? base : 8))); // straddle
		r = $urandom_range(0, 99);
		cnt = (r < 5) ? 0 : (r < 97) ? $urandom_range(1, 10) : $urandom_range(11, 255);
		cut = ($urandom_range(0, 24) == 0) ? $urandom_range(1, 3) : 0;
		maybe_noise();
		data_word(start);
		if (cut == 1)
			return;
		maybe_noise();
		data_word(8'(cnt));
		if (cut == 2)
			return;
		maybe_noise();
		data_word(8'($urandom));
		if (cut == 3)
			return;
		for (int i = 0; i < cnt; i++) begin
			maybe_noise();
			data_word(sb.pick_written());
		end
		maybe_noise();
		data_word(8'($urandom));
	endtask

	// One column: start, a few posts, usually the end marker, sometimes junk.
	task automatic gen_column();
		int nposts;
		send_word(OP_COL_START, COL_W'($urandom), RGB_W'($urandom), 8'($urandom));
		nposts = $urandom_range(0, 4);
		for (int i = 0; i < nposts; i++)
			gen_post();
		if ($urandom_range(0, 99) < 88) begin
			data_word(END_MARK);
			repeat ($urandom_range(0, 2)) data_word(8'($urandom)); // dropped after the end
		end else begin
			repeat ($urandom_range(0, 3)) data_word(8'($urandom));
		end
	endtask

	initial begin
		int heights [5];
		int h;
		int target;
		heights = '{1, 512, 511, 0, 64}; // 0: pick one at random
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset height of 128.
		send_word(OP_PAL_WRITE, 10'd0, 24'h123456, 8'h00);
		send_word(OP_PAL_WRITE, 10'h3FF, 24'hFFFFFF, 8'hFF); // wide index lands on entry 255
		send_word(OP_PAL_WRITE, 10'h155, 24'hA5A55A, 8'h00);
		send_word(OP_COL_START, 10'h3FF, 24'h000000, 8'h00); // last column
		data_word(8'd0);   // start row 0
		data_word(8'd2);   // two pixels
		data_word(8'd0);   // pad
		data_word(8'hFF);  // index 255, not an end marker here
		send_word(OP_PAL_WRITE, 10'h2AA, 24'h000000, 8'h00); // palette write inside a post
		send_word(OP_UNUSED, 10'h3FF, 24'hFFFFFF, 8'hFF);    // unused op, no effect
		data_word(8'd0);   // index 0
		data_word(8'd0);   // tail
		data_word(8'd10);  // empty post: row, count 0, pad, tail
		data_word(8'd0);
		data_word(8'd0);
		data_word(8'd0);
		data_word(8'd126); // rows 126..128, the last one below the picture
		data_word(8'd3);
		data_word(8'd0);
		data_word(8'hAA);
		data_word(8'h55);
		data_word(8'hFF);
		data_word(8'd0);
		data_word(END_MARK);
		data_word(8'd7);   // after the end marker: ignored
		send_word(OP_COL_START, 10'd0, 24'h000000, 8'h00);

		// Random part, one phase per height; the third phase runs without gaps.
		foreach (heights[p]) begin
			h = (heights[p] == 0) ? $urandom_range(2, 510) : heights[p];
			set_height(h);
			no_idle = (p == 2);
			target = work_words + 340;
			while (work_words < target)
				gen_column();
		end
		no_idle = 1'b0;

		drain();
		repeat (10) @(posedge clk);
		$display("Sent %0d active and %0d ignored input words over %0d picture heights;",
			work_words, ignored_words, heights_run);
		$display("checked %0d pixel words and %0d column ends, %0d mismatches.",
			sb.pixels_seen, sb.ends_seen, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_pixels.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Hard stop far beyond the slowest legal run.
	initial begin
		#5ms;
		$display("Timeout with %0d words still expected", sb.expected_pixels.size());
		$display("Verification failed");
		$finish;
	end

endmodule
